// ===== hw/rtl/vurft_pkg.sv =====
// ----------------------------------------------------------------------------
// vurft_pkg - shared types and constants
// Item and result structs, queue entry format and frame timing constants for
// the video unit register and frame timing block.
// ----------------------------------------------------------------------------
`default_nettype none

package vurft_pkg;

	// command codes of an input item
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// register numbers
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	// bit positions
	localparam int CTRL_NMI_BIT  = 7;
	localparam int CTRL_INC_BIT  = 2;
	localparam int STATUS_VBL_BIT = 7;

	// frame timing
	localparam logic [8:0] LAST_DOT      = 9'd340;
	localparam logic [8:0] LAST_LINE     = 9'd261;
	localparam logic [8:0] VBL_LINE      = 9'd241;
	localparam logic [8:0] NMI_LAST_LINE = 9'd260;

	// video address map
	localparam logic [15:0] PAT_LAST  = 16'h1FFF;
	localparam logic [15:0] NT_LAST   = 16'h2FFF;
	localparam logic [15:0] NT_BASE   = 16'h2000;
	localparam logic [15:0] STEP_WIDE = 16'd32;
	localparam logic [15:0] STEP_ONE  = 16'd1;
	localparam int          NT_SPAN   = int'(NT_LAST) - int'(NT_BASE) + 1;

	// dots of one tick: up to 7 cpu cycles times 3
	localparam int DOTS_W = 5;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [2:0] tick_cycles;
	} vurft_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        nmi_pulse;
		logic        vblank;
		logic        mem_write;
		logic        mem_target;
		logic [12:0] mem_addr;
		logic [7:0]  mem_data;
		logic        addr_error;
		logic [15:0] scroll_value;
	} vurft_result_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_WRITE,
		OP_READ,
		OP_NONE
	} vurft_op_t;

	// classified item as it sits in the queue
	typedef struct packed {
		vurft_op_t         op;
		logic [2:0]        reg_index;
		logic [7:0]        data;
		logic [DOTS_W-1:0] dots;
	} vurft_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/video_unit_register_and_frame_timing.sv =====
// ----------------------------------------------------------------------------
// video_unit_register_and_frame_timing - picture unit registers and timing
// Register file, scroll and video address latches, memory write issue and
// frame timing with vblank and nmi, without any rendering.
// ----------------------------------------------------------------------------
// Timing: a register write, read or unused command is queued, then popped
// while the executor is idle, and its result is registered; a tick of n cpu
// cycles walks 3n dots, one per clock, and gives its result after its last dot.
// Rate: one register item per cycle while no tick walks; a tick holds the
// executor until its last dot. A two entry queue takes items while it walks.
// Reset clears registers, latches, frame counters and the queue.
`default_nettype none

module video_unit_register_and_frame_timing #(
	parameter int NAME_TABLE_BYTES = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire vurft_pkg::vurft_item_t item,
	output logic                        done,
	output vurft_pkg::vurft_result_t    result
);
	import vurft_pkg::*;

	logic         head_valid;
	vurft_entry_t head;
	logic         pop;

	// intake and queue
	vurft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// execution
	vurft_back #(
		.NAME_TABLE_BYTES (NAME_TABLE_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/vurft_front.sv =====
// ----------------------------------------------------------------------------
// vurft_front - item intake and queue
// Accepts command items, classifies them into operations with a dot count
// and holds them in a two entry queue for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module vurft_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire vurft_pkg::vurft_item_t item,
	output logic                        head_valid,
	output vurft_pkg::vurft_entry_t     head,
	input  wire logic                   pop
);
	import vurft_pkg::*;

	localparam int DEPTH = 2;

	vurft_entry_t entries_q [DEPTH];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	vurft_entry_t cls;
	logic         push;

	// classify the incoming item
	always_comb begin
		cls.reg_index = item.reg_index;
		cls.data      = item.write_data;
		cls.dots      = {1'b0, item.tick_cycles, 1'b0} + {2'b00, item.tick_cycles};
		unique case (item.command)
			CMD_TICK:  cls.op = OP_TICK;
			CMD_WRITE: cls.op = OP_WRITE;
			CMD_READ:  cls.op = OP_READ;
			default:   cls.op = OP_NONE;
		endcase
	end

	assign busy       = (count_q == 2'(DEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != 2'd0);
	assign head       = entries_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue count out of range");

	// pop only from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	// pointers agree with the count
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hw/rtl/vurft_back.sv =====
// ----------------------------------------------------------------------------
// vurft_back - register file and dot walker
// Executes queued operations: register writes and reads with their side
// effects, video memory write issue, and tick frame timing, one dot per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module vurft_back #(
	parameter int NAME_TABLE_BYTES = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    head_valid,
	input  wire vurft_pkg::vurft_entry_t head,
	output logic                         pop,
	output logic                         done,
	output vurft_pkg::vurft_result_t     result
);
	import vurft_pkg::*;

	localparam logic [12:0] NT_BYTES = 13'(NAME_TABLE_BYTES);
	localparam int          NT_STEPS = (NT_SPAN - 1) / NAME_TABLE_BYTES;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t            state_q;
	logic [7:0]        reg_file_q [8];
	logic              toggle_q;
	logic [15:0]       scroll_q;
	logic [15:0]       vaddr_q;
	logic [8:0]        line_q;
	logic [8:0]        dot_q;
	logic [DOTS_W-1:0] dots_left_q;
	logic              nmi_q;
	logic              done_q;
	vurft_result_t     res_q;

	logic [7:0]    rd_byte;
	logic [11:0]   nt_off;
	logic          in_pat;
	logic          in_nt;
	logic          addr_err;
	logic [15:0]   step;
	logic          at_dot0;
	logic          vbl_set;
	logic          vbl_clr;
	logic          dot_nmi;
	logic          dot_vbl;
	logic [8:0]    dot_nx;
	logic [8:0]    line_nx;
	vurft_result_t op_res;
	vurft_result_t dot_res;

	assign pop    = head_valid && (state_q == S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// name table offset: mirror by repeated subtract of the table size
	always_comb begin
		nt_off = vaddr_q[11:0];
		for (int i = 0; i < NT_STEPS; i++) begin
			if ({1'b0, nt_off} >= NT_BYTES) begin
				nt_off = 12'({1'b0, nt_off} - NT_BYTES);
			end
		end
	end

	// address decode and step size
	assign rd_byte  = reg_file_q[head.reg_index];
	assign in_pat   = (vaddr_q <= PAT_LAST);
	assign in_nt    = !in_pat && (vaddr_q <= NT_LAST);
	assign addr_err = !in_pat && !in_nt;
	assign step     = reg_file_q[REG_CTRL][CTRL_INC_BIT] ? STEP_WIDE : STEP_ONE;

	// per dot events and counter advance
	assign at_dot0 = (dot_q == 9'd0);
	assign vbl_set = at_dot0 && (line_q == VBL_LINE);
	assign vbl_clr = at_dot0 && (line_q == LAST_LINE);
	assign dot_nmi = at_dot0 && (line_q >= VBL_LINE) && (line_q <= NMI_LAST_LINE)
		&& reg_file_q[REG_CTRL][CTRL_NMI_BIT];
	assign dot_vbl = vbl_set || (reg_file_q[REG_STATUS][STATUS_VBL_BIT] && !vbl_clr);
	assign dot_nx  = (dot_q == LAST_DOT) ? 9'd0 : dot_q + 9'd1;
	assign line_nx = (dot_q != LAST_DOT) ? line_q :
		(line_q == LAST_LINE) ? 9'd0 : line_q + 9'd1;

	// result of a register operation
	always_comb begin
		op_res              = '0;
		op_res.vblank       = reg_file_q[REG_STATUS][STATUS_VBL_BIT];
		op_res.scroll_value = scroll_q;
		unique case (head.op)
			OP_WRITE: begin
				unique case (head.reg_index)
					REG_STATUS: op_res.vblank = head.data[STATUS_VBL_BIT];
					REG_SCROLL: op_res.scroll_value = toggle_q ?
						(scroll_q | {8'h00, head.data}) : {head.data, 8'h00};
					REG_DATA: begin
						op_res.addr_error = addr_err;
						if (!addr_err) begin
							op_res.mem_write  = 1'b1;
							op_res.mem_target = in_nt;
							op_res.mem_addr   = in_nt ? {1'b0, nt_off} : vaddr_q[12:0];
							op_res.mem_data   = head.data;
						end
					end
					default: ;
				endcase
			end
			OP_READ: begin
				op_res.read_data = rd_byte;
				if (head.reg_index == REG_STATUS) begin
					op_res.vblank = 1'b0;
				end
			end
			OP_TICK, OP_NONE: ;
		endcase
	end

	// result of the last dot of a tick
	always_comb begin
		dot_res              = '0;
		dot_res.nmi_pulse    = nmi_q || dot_nmi;
		dot_res.vblank       = dot_vbl;
		dot_res.scroll_value = scroll_q;
	end

	// payload of the result register
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= op_res;
		end else if (state_q == S_RUN) begin
			res_q <= dot_res;
		end
	end

	// sequencer, register file and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < 8; i++) begin
				reg_file_q[i] <= 8'h00;
			end
			toggle_q    <= 1'b0;
			scroll_q    <= 16'h0000;
			vaddr_q     <= 16'h0000;
			line_q      <= 9'd0;
			dot_q       <= 9'd0;
			dots_left_q <= '0;
			nmi_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (head.op)
							OP_TICK: begin
								if (head.dots == '0) begin
									done_q <= 1'b1;
								end else begin
									dots_left_q <= head.dots;
									nmi_q       <= 1'b0;
									state_q     <= S_RUN;
								end
							end
							OP_WRITE: begin
								done_q <= 1'b1;
								reg_file_q[head.reg_index] <= head.data;
								unique case (head.reg_index)
									REG_SCROLL: begin
										scroll_q <= op_res.scroll_value;
										toggle_q <= !toggle_q;
									end
									REG_ADDR: begin
										vaddr_q  <= toggle_q ?
											(vaddr_q | {8'h00, head.data}) :
											{head.data, 8'h00};
										toggle_q <= !toggle_q;
									end
									REG_DATA: begin
										if (!addr_err) begin
											vaddr_q <= vaddr_q + step;
										end
									end
									default: ;
								endcase
							end
							OP_READ: begin
								done_q <= 1'b1;
								if (head.reg_index == REG_STATUS) begin
									reg_file_q[REG_STATUS][STATUS_VBL_BIT] <= 1'b0;
									toggle_q <= 1'b0;
								end
							end
							OP_NONE: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_RUN: begin
					reg_file_q[REG_STATUS][STATUS_VBL_BIT] <= dot_vbl;
					nmi_q       <= nmi_q || dot_nmi;
					dot_q       <= dot_nx;
					line_q      <= line_nx;
					dots_left_q <= dots_left_q - DOTS_W'(1);
					if (dots_left_q == DOTS_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// frame counters stay inside the frame
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dot_q <= LAST_DOT) && (line_q <= LAST_LINE))
		else $error("frame counter out of range");

	// a running tick always has dots left
	a_run_dots: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (dots_left_q != '0))
		else $error("dot walker running with no dots left");

	// an error never issues a memory write
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(res_q.addr_error && res_q.mem_write))
		else $error("memory write issued with address error");

	// a result follows the end of the dot walk
	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RUN) && (dots_left_q == DOTS_W'(1))) |=> done_q)
		else $error("tick finished without a result");

endmodule

`default_nettype wire
